>>> design/wsdf_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket deframer package
// Result kind codes and widths shared by the deframer.
// ----------------------------------------------------------------------------
package wsdf_pkg;

  localparam int unsigned KindWidth = 2;

  typedef logic [KindWidth-1:0] kind_t;

  localparam kind_t KIND_PAYLOAD = 2'd0;
  localparam kind_t KIND_EMPTY   = 2'd1;
  localparam kind_t KIND_REJECT  = 2'd2;

  localparam logic [3:0] OPCODE_TEXT  = 4'h1;
  localparam logic [3:0] OPCODE_CLOSE = 4'h8;

  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

endpackage

>>> design/websocket_frame_deframer_top.sv
// ----------------------------------------------------------------------------
// WebSocket frame deframer
// Parses a byte stream of WebSocket frames, one byte per transfer, and emits
// unmasked payload bytes, empty-frame markers and opcode rejections.
//
// Input channel: in_valid / in_ready with data_byte, one raw stream byte.
// Output channel: out_valid / out_ready with kind, payload_byte,
// frame_opcode, final_flag and end_of_frame. A byte gives zero or one result.
// Header bytes (length, extended length, masking key) give no result, except
// an empty frame (one kind 1 result with end_of_frame) and an unsupported
// opcode (one kind 2 result on the first header byte, then the frame is
// skipped silently).
// The parser state and the result register are both written at the edge that
// takes the byte. Throughput is one byte per cycle, set by the single result
// register; in_ready stays high while that register is empty or being
// drained in the same cycle.
// When the receiver stalls, the result is held and in_ready falls until it
// is taken. Synchronous reset returns the parser to the first header byte
// with an empty result register.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top
  import wsdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output kind_t       kind,
  output logic [7:0]  payload_byte,
  output logic [3:0]  frame_opcode,
  output logic        final_flag,
  output logic        end_of_frame
);

  typedef enum logic [2:0] {
    PH_HDR1  = 3'd0,
    PH_HDR2  = 3'd1,
    PH_EXT16 = 3'd2,
    PH_EXT64 = 3'd3,
    PH_MASK  = 3'd4,
    PH_DATA  = 3'd5
  } phase_t;

  phase_t      phase, phase_next;
  logic        fin_bit, fin_bit_next;
  logic [3:0]  opcode_reg, opcode_reg_next;
  logic        mask_present, mask_present_next;
  logic [2:0]  header_byte_count, header_byte_count_next;
  logic [63:0] remaining_length, remaining_length_next;
  logic [31:0] mask_key, mask_key_next;
  logic [1:0]  mask_index, mask_index_next;
  logic        discard_frame, discard_frame_next;

  logic        emit;
  kind_t       emit_kind;
  logic [7:0]  emit_byte;
  logic        emit_eof;
  logic        length_done;
  logic        header_done;
  logic [2:0]  ext_last;
  logic [7:0]  key_byte;
  logic        fire;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    unique case (mask_index)
      2'd0: key_byte = mask_key[31:24];
      2'd1: key_byte = mask_key[23:16];
      2'd2: key_byte = mask_key[15:8];
      default: key_byte = mask_key[7:0];
    endcase
  end

  always_comb begin
    phase_next             = phase;
    fin_bit_next           = fin_bit;
    opcode_reg_next        = opcode_reg;
    mask_present_next      = mask_present;
    header_byte_count_next = header_byte_count;
    remaining_length_next  = remaining_length;
    mask_key_next          = mask_key;
    mask_index_next        = mask_index;
    discard_frame_next     = discard_frame;
    emit                   = 1'b0;
    emit_kind              = KIND_PAYLOAD;
    emit_byte              = 8'd0;
    emit_eof               = 1'b0;
    length_done            = 1'b0;
    header_done            = 1'b0;
    ext_last               = (phase == PH_EXT16) ? EXT16_LAST : EXT64_LAST;

    unique case (phase)
      PH_HDR2: begin
        mask_present_next      = data_byte[7];
        header_byte_count_next = 3'd0;
        remaining_length_next  = 64'd0;
        if (data_byte[6:0] == LEN_EXT16) begin
          phase_next = PH_EXT16;
        end else if (data_byte[6:0] == LEN_EXT64) begin
          phase_next = PH_EXT64;
        end else begin
          remaining_length_next = {57'd0, data_byte[6:0]};
          length_done           = 1'b1;
        end
      end
      PH_EXT16, PH_EXT64: begin
        remaining_length_next = {remaining_length[55:0], data_byte};
        if (header_byte_count >= ext_last) begin
          length_done = 1'b1;
        end else begin
          header_byte_count_next = header_byte_count + 3'd1;
        end
      end
      PH_MASK: begin
        mask_key_next = {mask_key[23:0], data_byte};
        if (header_byte_count >= KEY_LAST) begin
          header_done = 1'b1;
        end else begin
          header_byte_count_next = header_byte_count + 3'd1;
        end
      end
      PH_DATA: begin
        remaining_length_next = remaining_length - 64'd1;
        emit_eof              = (remaining_length_next == 64'd0);
        if (emit_eof) begin
          phase_next = PH_HDR1;
        end
        if (!discard_frame) begin
          mask_index_next = mask_index + 2'd1;
          emit            = 1'b1;
          emit_kind       = KIND_PAYLOAD;
          emit_byte       = data_byte ^ key_byte;
        end
      end
      default: begin
        fin_bit_next           = data_byte[7];
        opcode_reg_next        = data_byte[3:0];
        mask_present_next      = 1'b0;
        mask_key_next          = 32'd0;
        mask_index_next        = 2'd0;
        remaining_length_next  = 64'd0;
        header_byte_count_next = 3'd0;
        phase_next             = PH_HDR2;
        if (data_byte[3:0] != OPCODE_TEXT && data_byte[3:0] != OPCODE_CLOSE) begin
          discard_frame_next = 1'b1;
          emit               = 1'b1;
          emit_kind          = KIND_REJECT;
        end else begin
          discard_frame_next = 1'b0;
        end
      end
    endcase

    if (length_done) begin
      if (mask_present_next) begin
        phase_next             = PH_MASK;
        header_byte_count_next = 3'd0;
      end else begin
        header_done = 1'b1;
      end
    end

    if (header_done) begin
      mask_index_next = 2'd0;
      if (remaining_length_next == 64'd0) begin
        phase_next = PH_HDR1;
        if (!discard_frame) begin
          emit      = 1'b1;
          emit_kind = KIND_EMPTY;
          emit_eof  = 1'b1;
        end
      end else begin
        phase_next = PH_DATA;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HDR1;
      fin_bit           <= 1'b0;
      opcode_reg        <= 4'd0;
      mask_present      <= 1'b0;
      header_byte_count <= 3'd0;
      remaining_length  <= 64'd0;
      mask_key          <= 32'd0;
      mask_index        <= 2'd0;
      discard_frame     <= 1'b0;
      out_valid         <= 1'b0;
    end else begin
      if (fire) begin
        phase             <= phase_next;
        fin_bit           <= fin_bit_next;
        opcode_reg        <= opcode_reg_next;
        mask_present      <= mask_present_next;
        header_byte_count <= header_byte_count_next;
        remaining_length  <= remaining_length_next;
        mask_key          <= mask_key_next;
        mask_index        <= mask_index_next;
        discard_frame     <= discard_frame_next;
      end
      if (in_ready) begin
        out_valid <= fire && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      kind         <= emit_kind;
      payload_byte <= emit_byte;
      frame_opcode <= opcode_reg_next;
      final_flag   <= fin_bit_next;
      end_of_frame <= emit_eof;
    end
  end

  a_zero_unless_payload: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_PAYLOAD |-> payload_byte == 8'd0)
    else $error("non-payload result carries a data byte");

  a_reject_not_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_REJECT |-> !end_of_frame)
    else $error("rejection marked as end of frame");

  a_empty_is_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_EMPTY |-> end_of_frame)
    else $error("empty-frame result without end of frame");

  a_discard_silent: assert property (@(posedge clk) disable iff (rst)
    fire && phase == PH_DATA && discard_frame |=> !out_valid)
    else $error("skipped frame produced a result");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(payload_byte))
    else $error("stalled result lost or changed");

endmodule

>>> tb/sv/tb_websocket_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// WebSocket frame deframer testbench
// Sends streams of frames one byte per transfer. A behavioral parser in the
// testbench predicts every payload byte, empty-frame marker and opcode
// rejection, and the results are checked in order as they leave the block.
// The covered cases are masked and unmasked frames, 7/16/64-bit lengths,
// skipped frames, reserved bits and an all-ones 64-bit length. Both sides
// stall at random.
// ----------------------------------------------------------------------------
module tb_websocket_frame_deframer_top;
  import wsdf_pkg::*;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned PhaseBytes = 200;

  typedef enum logic [2:0] {
    HDR_FIRST, HDR_SECOND, EXT_LEN16, EXT_LEN64, MASK_KEY, PAYLOAD
  } parse_phase_t;

  typedef enum int {LEN_SHORT, LEN_WIDE16, LEN_WIDE64} len_form_t;

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [3:0] opcode;
    logic       fin;
    logic       eof;
  } frame_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  kind_t      kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       final_flag;
  logic       end_of_frame;

  parse_phase_t  phase = HDR_FIRST;
  logic          fin_bit = 1'b0;
  logic [3:0]    opcode = 4'h0;
  logic          mask_on = 1'b0;
  logic [2:0]    hdr_count = 3'd0;
  logic [63:0]   remaining = 64'd0;
  logic [31:0]   key = 32'd0;
  logic [1:0]    key_idx = 2'd0;
  logic          skipping = 1'b0;

  frame_result_t pending_results[$];
  int unsigned   error_count = 0;
  int unsigned   bytes_sent = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;

  websocket_frame_deframer_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_opcode (frame_opcode),
    .final_flag   (final_flag),
    .end_of_frame (end_of_frame)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void expect_result(kind_t k, logic [7:0] d, logic eof);
    frame_result_t r;
    r.kind   = k;
    r.data   = d;
    r.opcode = opcode;
    r.fin    = fin_bit;
    r.eof    = eof;
    pending_results.push_back(r);
  endfunction

  function automatic void finish_header();
    key_idx = 2'd0;
    if (remaining == 64'd0) begin
      phase = HDR_FIRST;
      if (!skipping) expect_result(KIND_EMPTY, 8'h00, 1'b1);
    end else begin
      phase = PAYLOAD;
    end
  endfunction

  function automatic void finish_length();
    if (mask_on) begin
      phase = MASK_KEY;
      hdr_count = 3'd0;
    end else begin
      finish_header();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] key_byte;
    logic       eof;
    logic [2:0] last;
    case (phase)
      HDR_SECOND: begin
        mask_on = b[7];
        hdr_count = 3'd0;
        remaining = 64'd0;
        if (b[6:0] == LEN_EXT16) begin
          phase = EXT_LEN16;
        end else if (b[6:0] == LEN_EXT64) begin
          phase = EXT_LEN64;
        end else begin
          remaining = {57'd0, b[6:0]};
          finish_length();
        end
      end
      EXT_LEN16, EXT_LEN64: begin
        last = (phase == EXT_LEN16) ? EXT16_LAST : EXT64_LAST;
        remaining = {remaining[55:0], b};
        if (hdr_count >= last) finish_length();
        else hdr_count = hdr_count + 3'd1;
      end
      MASK_KEY: begin
        key = {key[23:0], b};
        if (hdr_count >= KEY_LAST) finish_header();
        else hdr_count = hdr_count + 3'd1;
      end
      PAYLOAD: begin
        remaining = remaining - 64'd1;
        eof = (remaining == 64'd0);
        if (eof) phase = HDR_FIRST;
        if (!skipping) begin
          key_byte = key[(3 - key_idx) * 8 +: 8];
          key_idx = key_idx + 2'd1;
          expect_result(KIND_PAYLOAD, b ^ key_byte, eof);
        end
      end
      default: begin
        fin_bit = b[7];
        opcode = b[3:0];
        mask_on = 1'b0;
        key = 32'd0;
        key_idx = 2'd0;
        remaining = 64'd0;
        hdr_count = 3'd0;
        phase = HDR_SECOND;
        skipping = (opcode != OPCODE_TEXT) && (opcode != OPCODE_CLOSE);
        if (skipping) expect_result(KIND_REJECT, 8'h00, 1'b0);
      end
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic masked,
                            input len_form_t form, input int unsigned len);
    logic [31:0] key_bytes;
    key_bytes = $urandom;
    send_byte({fin, 3'($urandom_range(7)), op});
    case (form)
      LEN_WIDE16: begin
        send_byte({masked, LEN_EXT16});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
      end
      LEN_WIDE64: begin
        send_byte({masked, LEN_EXT64});
        for (int i = 7; i >= 0; i--) send_byte(8'(64'(len) >> (8 * i)));
      end
      default: send_byte({masked, 7'(len)});
    endcase
    if (masked) begin
      for (int i = 3; i >= 0; i--) send_byte(key_bytes[8 * i +: 8]);
    end
    repeat (len) send_byte(8'($urandom));
  endtask

  task automatic test_empty_text_frame();
    send_byte(8'h81);
    send_byte(8'h00);
  endtask

  task automatic test_masked_close_frame();
    send_byte(8'h08);
    send_byte(8'h82);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  task automatic test_rejected_opcodes();
    send_byte(8'h7F);
    send_byte(8'h00);
    send_byte(8'hF0);
    send_byte(8'h01);
    send_byte(8'hAA);
  endtask

  task automatic test_short_extended_lengths();
    send_byte(8'hC1);
    send_byte({1'b0, LEN_EXT16});
    send_byte(8'h00);
    send_byte(8'h01);
    send_byte(8'h3C);
    send_byte(8'h88);
    send_byte({1'b0, LEN_EXT64});
    repeat (8) send_byte(8'h00);
  endtask

  task automatic test_random_frames(input int unsigned budget);
    int unsigned stop_at;
    int unsigned pick;
    logic [3:0]  op;
    len_form_t   form;
    int unsigned len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 80) op = $urandom_range(1) ? OPCODE_TEXT : OPCODE_CLOSE;
      else op = 4'($urandom_range(15));
      pick = $urandom_range(99);
      if (pick < 70) begin
        form = LEN_SHORT;
        len = ($urandom_range(19) == 0) ? $urandom_range(125, 40) : $urandom_range(12);
      end else if (pick < 85) begin
        form = LEN_WIDE16;
        len = ($urandom_range(9) == 0) ? $urandom_range(300, 200) : $urandom_range(20);
      end else begin
        form = LEN_WIDE64;
        len = $urandom_range(20);
      end
      send_frame(1'($urandom_range(1)), op, 1'($urandom_range(1)), form, len);
      if ($urandom_range(29) == 0) wait_for_drain();
    end
  endtask

  // Leave the stream inside a frame whose 64-bit length is all ones.
  task automatic test_all_ones_length();
    send_byte(8'h81);
    send_byte({1'b1, LEN_EXT64});
    repeat (8) send_byte(8'hFF);
    send_byte(8'h0F);
    send_byte(8'hF0);
    send_byte(8'h55);
    send_byte(8'hAA);
    repeat (6) send_byte(8'($urandom));
  endtask

  always @(posedge clk) begin
    frame_result_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= MaxReports)
          $display("unexpected result: kind %0d data %02h op %h fin %b eof %b",
                   kind, payload_byte, frame_opcode, final_flag, end_of_frame);
      end else begin
        exp_r = pending_results.pop_front();
        if (kind !== exp_r.kind || payload_byte !== exp_r.data ||
            frame_opcode !== exp_r.opcode || final_flag !== exp_r.fin ||
            end_of_frame !== exp_r.eof) begin
          error_count++;
          if (error_count <= MaxReports)
            $display("mismatch: expected kind %0d data %02h op %h fin %b eof %b, %s",
                     exp_r.kind, exp_r.data, exp_r.opcode, exp_r.fin, exp_r.eof,
                     $sformatf("got kind %0d data %02h op %h fin %b eof %b",
                               kind, payload_byte, frame_opcode, final_flag,
                               end_of_frame));
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 25;
    recv_idle_pct = 85;
    test_empty_text_frame();
    test_masked_close_frame();
    test_rejected_opcodes();
    test_short_extended_lengths();
    wait_for_drain();
    test_random_frames(PhaseBytes);
    wait_for_drain();
    send_idle_pct = 85;
    recv_idle_pct = 25;
    test_random_frames(PhaseBytes);
    wait_for_drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_frames(PhaseBytes);
    test_all_ones_length();
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
